[design/lmvts_pkg.sv]
package lmvts_pkg;

    localparam int MATRIX_SIZE  = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int COL_BITS     = $clog2(MATRIX_SIZE);
    localparam int TICK_BITS    = 8;
    localparam int REM_BITS     = SAMPLE_BITS + 1;
    localparam int IN_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PATTERN_BITS = 2 * MATRIX_SIZE;
    localparam int OUT_FIELDS_W = PATTERN_BITS + 1 + COL_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // reset values of the registers and state
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RST = SAMPLE_BITS'(1024);
    localparam logic [TICK_BITS-1:0]   TICKS_RST      = TICK_BITS'(10);
    localparam logic [COL_BITS-1:0]    COLUMN_RST     = COL_BITS'(4);
    localparam logic [COL_BITS-1:0]    TOP_LEVEL      = COL_BITS'(MATRIX_SIZE - 1);

    // configuration register indexes
    localparam logic CFG_FULL_SCALE = 1'b0;
    localparam logic CFG_TICKS      = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_SAMPLE  = 2'd1,
        REQ_REFRESH = 2'd2
    } req_type_t;

    // level unit request and response
    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] dividend;
        logic [SAMPLE_BITS-1:0] divisor;
    } lvl_req_t;

    typedef struct packed {
        logic                done;
        logic [COL_BITS-1:0] level;
    } lvl_rsp_t;

endpackage

[design/lmvts_level.sv]
module lmvts_level (
    input  logic               clk,
    input  logic               rst_n,
    input  lmvts_pkg::lvl_req_t req,
    output lmvts_pkg::lvl_rsp_t rsp
);
    import lmvts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } lvl_state_t;

    lvl_state_t             state_reg, state_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] div_reg, div_next;
    logic [COL_BITS-1:0]    quo_reg, quo_next;
    logic [1:0]             cnt_reg, cnt_next;

    // shared compare/subtract unit
    logic [REM_BITS:0] diff;
    logic              fits;

    assign diff = {1'b0, rem_reg} - {2'b00, div_reg};
    assign fits = ~diff[REM_BITS];

    // saturating check, then one quotient bit per step
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = {1'b0, req.dividend};
                    div_next   = req.divisor;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (fits)
                begin
                    quo_next   = TOP_LEVEL;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = {rem_reg[REM_BITS-2:0], 1'b0};
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (fits)
                begin
                    rem_next = {diff[REM_BITS-2:0], 1'b0};
                end
                else
                begin
                    rem_next = {rem_reg[REM_BITS-2:0], 1'b0};
                end
                quo_next = {quo_reg[COL_BITS-2:0], fits};
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'(COL_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state and working values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
            quo_reg   <= quo_next;
        end
    end

    assign rsp.done  = (state_reg == ST_DONE);
    assign rsp.level = quo_reg;

endmodule

[design/led_matrix_voltage_trace_scanner_top.sv]
// Channel | Direction | Ports                          | Word
// --------+-----------+--------------------------------+-------------------------------
// s       | in        | s_tvalid s_tready s_tdata/tuser| request kind, converter sample
// m       | out       | m_tvalid m_tready m_tdata      | pattern, request flag, column
// cfg     | in        | cfg_we cfg_addr cfg_data       | full scale, ticks per sample
//
// Tick and sample words have their result registered in the cycle after they are taken.
// A refresh word waits for the level unit, which does one saturation compare, then 3
// compare/subtract steps, one quotient bit per cycle, then hands back the level; a
// saturated level skips the steps, and the output word registers the returned level.
// rst_n clears all state at once; the history reads as zero and the column is 4.
// s_tready is low while the level unit works and while a result stalls on m_tready.
module led_matrix_voltage_trace_scanner_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lmvts_pkg::IN_DATA_W-1:0]      s_tdata,  // sample_value
    input  logic [1:0]                           s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lmvts_pkg::OUT_DATA_W-1:0]     m_tdata,  // drive_pattern,
                                                           // sample_request, shown_column
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  logic [lmvts_pkg::SAMPLE_BITS-1:0]    cfg_data
);
    import lmvts_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } top_state_t;

    top_state_t               state_reg, state_next;
    logic [SAMPLE_BITS-1:0]   full_scale_reg;
    logic [TICK_BITS-1:0]     ticks_reg;
    logic [SAMPLE_BITS-1:0]   hist_reg [MATRIX_SIZE];
    logic [COL_BITS-1:0]      col_reg, col_next;
    logic [TICK_BITS-1:0]     tick_reg, tick_next;
    logic                     pend_reg, pend_next;
    logic                     mvalid_reg, mvalid_next;
    logic [PATTERN_BITS-1:0]  pat_reg, pat_next;
    logic                     oreq_reg, oreq_next;
    logic [COL_BITS-1:0]      ocol_reg, ocol_next;
    logic                     shift_en;

    logic                     accept;
    req_type_t                kind;
    logic [SAMPLE_BITS-1:0]   sample;
    logic [COL_BITS-1:0]      col_inc;
    logic [TICK_BITS-1:0]     tick_inc;
    logic [COL_BITS-1:0]      row;
    lvl_req_t                 lvl_req;
    lvl_rsp_t                 lvl_rsp;

    assign kind     = req_type_t'(s_tuser);
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign col_inc  = col_reg + COL_BITS'(1);
    assign tick_inc = tick_reg + TICK_BITS'(1);
    assign row      = TOP_LEVEL - lvl_rsp.level;

    // start the level unit on the column that the refresh moves to
    assign lvl_req.start    = accept && (kind == REQ_REFRESH);
    assign lvl_req.dividend = hist_reg[col_inc];
    assign lvl_req.divisor  = full_scale_reg;

    lmvts_level u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lvl_req),
        .rsp   (lvl_rsp)
    );

    // decode the word and build the result
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        tick_next   = tick_reg;
        pend_next   = pend_reg;
        shift_en    = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        pat_next    = pat_reg;
        oreq_next   = oreq_reg;
        ocol_next   = ocol_reg;
        if (accept)
        begin
            unique case (kind)
                REQ_TICK:
                begin
                    if (tick_inc == ticks_reg)
                    begin
                        tick_next = '0;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                REQ_SAMPLE:
                begin
                    if (pend_reg)
                    begin
                        shift_en  = 1'b1;
                        pend_next = 1'b0;
                    end
                end
                REQ_REFRESH:
                begin
                    col_next   = col_inc;
                    state_next = ST_WAIT;
                end
                default:
                begin
                end
            endcase
            if (kind != REQ_REFRESH)
            begin
                mvalid_next = 1'b1;
                pat_next    = '0;
                oreq_next   = pend_next;
                ocol_next   = '0;
            end
        end
        else if (state_reg == ST_WAIT && lvl_rsp.done)
        begin
            state_next  = ST_IDLE;
            mvalid_next = 1'b1;
            pat_next    = {MATRIX_SIZE'(1) << col_reg, MATRIX_SIZE'(1) << row};
            oreq_next   = pend_reg;
            ocol_next   = col_reg;
        end
    end

    // hold control, output word, configuration and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            full_scale_reg <= FULL_SCALE_RST;
            ticks_reg      <= TICKS_RST;
            col_reg        <= COLUMN_RST;
            tick_reg       <= '0;
            pend_reg       <= 1'b0;
            mvalid_reg     <= 1'b0;
            pat_reg        <= '0;
            oreq_reg       <= 1'b0;
            ocol_reg       <= '0;
            for (int i = 0; i < MATRIX_SIZE; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            tick_reg   <= tick_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
            pat_reg    <= pat_next;
            oreq_reg   <= oreq_next;
            ocol_reg   <= ocol_next;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_FULL_SCALE)
                begin
                    full_scale_reg <= cfg_data;
                end
                else
                begin
                    ticks_reg <= cfg_data[TICK_BITS-1:0];
                end
            end
            if (shift_en)
            begin
                for (int i = MATRIX_SIZE - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= sample;
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), ocol_reg, oreq_reg, pat_reg};

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> !s_tready)
        else $error("input taken while level unit busy");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_rsp.done |-> (state_reg == ST_WAIT))
        else $error("level unit finished with no refresh pending");

    a_refresh_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_req.start |=> (state_reg == ST_WAIT))
        else $error("refresh did not enter wait");

    a_pattern_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($onehot0(pat_reg[PATTERN_BITS-1:MATRIX_SIZE])
                      && $onehot0(pat_reg[MATRIX_SIZE-1:0])
                      && ((pat_reg[PATTERN_BITS-1:MATRIX_SIZE] == '0)
                          == (pat_reg[MATRIX_SIZE-1:0] == '0))))
        else $error("drive pattern not one column and one row");
`endif

endmodule
